[rtl/clt_pkg.sv]
package clt_pkg;

  localparam int TOKEN_LIMIT = 64;
  localparam int WORD_LIMIT  = 256;

  localparam int CH_W  = 8;
  localparam int IDX_W = 6;
  localparam int TD_W  = $clog2(TOKEN_LIMIT);
  localparam int WL_W  = $clog2(WORD_LIMIT);

  localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_AMP   = 8'h26;
  localparam logic [CH_W-1:0] CH_LT    = 8'h3C;
  localparam logic [CH_W-1:0] CH_GT    = 8'h3E;
  localparam logic [CH_W-1:0] CH_PIPE  = 8'h7C;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_PEND,
    MODE_SKIP
  } mode_e;

  typedef enum logic [2:0] {
    KIND_WORD   = 3'd0,
    KIND_PIPE   = 3'd1,
    KIND_IN     = 3'd2,
    KIND_OUT    = 3'd3,
    KIND_APPEND = 3'd4,
    KIND_BG     = 3'd5,
    KIND_END    = 3'd6
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [CH_W-1:0]   wchar;
    logic              tend;
    logic [IDX_W-1:0]  tidx;
    logic              last;
  } res_t;

  function automatic logic is_blank(input logic [CH_W-1:0] c);
    return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
  endfunction

  function automatic logic is_delim(input logic [CH_W-1:0] c);
    return (c == CH_NUL) || is_blank(c) || (c == CH_PIPE) || (c == CH_LT) ||
           (c == CH_GT) || (c == CH_AMP);
  endfunction

endpackage

[rtl/clt_if.sv]
interface clt_in_if;
  import clt_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

interface clt_out_if;
  import clt_pkg::*;

  logic             valid;
  logic             ready;
  logic [2:0]       token_kind;
  logic [CH_W-1:0]  word_char;
  logic             token_closes;
  logic [IDX_W-1:0] token_index;
  logic             run_last;

  modport source (output valid, output token_kind, output word_char, output token_closes,
                  output token_index, output run_last, input ready);
  modport sink (input valid, input token_kind, input word_char, input token_closes,
                input token_index, input run_last, output ready);
endinterface

[rtl/clt_step.sv]
module clt_step
  import clt_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            take_i,
  input  logic [CH_W-1:0] ch_i,
  output res_t            res0_o,
  output res_t            res1_o,
  output logic [1:0]      count_o
);

  mode_e            mode_q, mode_d;
  logic [TD_W-1:0]  td_q, td_d;
  logic [WL_W-1:0]  wl_q, wl_d;

  function automatic mode_e fin_mode(input logic [TD_W-1:0] td);
    return (td >= TD_W'(TOKEN_LIMIT - 1)) ? MODE_SKIP : MODE_IDLE;
  endfunction

  function automatic res_t mk(input kind_e k, input logic [CH_W-1:0] c, input logic e,
                              input logic [TD_W-1:0] td);
    res_t r;
    r.kind  = k;
    r.wchar = c;
    r.tend  = e;
    r.tidx  = IDX_W'(td);
    r.last  = 1'b0;
    return r;
  endfunction

  mode_e            mode_a;
  logic [TD_W-1:0]  td_a;
  logic [WL_W-1:0]  wl_a;
  logic             va, vb, go_on, full;
  res_t             ra, rb;

  always_comb begin
    // first result: word close or the pending '>' resolution
    mode_a = mode_q;
    td_a   = td_q;
    wl_a   = wl_q;
    va     = 1'b0;
    ra     = '0;
    go_on  = 1'b1;
    if (mode_q == MODE_WORD && is_delim(ch_i)) begin
      va     = 1'b1;
      ra     = mk(KIND_WORD, CH_NUL, 1'b1, td_q);
      td_a   = td_q + TD_W'(1);
      wl_a   = '0;
      mode_a = fin_mode(td_a);
    end else if (mode_q == MODE_PEND) begin
      va     = 1'b1;
      ra     = mk((ch_i == CH_GT) ? KIND_APPEND : KIND_OUT, CH_NUL, 1'b1, td_q);
      td_a   = td_q + TD_W'(1);
      wl_a   = '0;
      mode_a = fin_mode(td_a);
      go_on  = (ch_i != CH_GT);
    end

    // second result: the character itself
    mode_d = mode_a;
    td_d   = td_a;
    wl_d   = wl_a;
    vb     = 1'b0;
    rb     = '0;
    full   = (wl_a >= WL_W'(WORD_LIMIT - 2));
    if (go_on) begin
      if (ch_i == CH_NUL) begin
        vb     = 1'b1;
        rb     = mk(KIND_END, CH_NUL, 1'b1, td_a);
        mode_d = MODE_IDLE;
        td_d   = '0;
        wl_d   = '0;
      end else if (mode_a == MODE_SKIP || is_blank(ch_i)) begin
        vb = 1'b0;
      end else if (ch_i == CH_PIPE || ch_i == CH_LT || ch_i == CH_AMP) begin
        vb     = 1'b1;
        rb     = mk((ch_i == CH_PIPE) ? KIND_PIPE : (ch_i == CH_LT) ? KIND_IN : KIND_BG,
                    CH_NUL, 1'b1, td_a);
        td_d   = td_a + TD_W'(1);
        wl_d   = '0;
        mode_d = fin_mode(td_d);
      end else if (ch_i == CH_GT) begin
        mode_d = MODE_PEND;
      end else begin
        vb = 1'b1;
        rb = mk(KIND_WORD, ch_i, full, td_a);
        if (full) begin
          // word hits the length cap: this character closes it
          td_d   = td_a + TD_W'(1);
          wl_d   = '0;
          mode_d = fin_mode(td_d);
        end else begin
          wl_d   = wl_a + WL_W'(1);
          mode_d = MODE_WORD;
        end
      end
    end

    res0_o      = va ? ra : rb;
    res1_o      = rb;
    res0_o.last = !(va && vb);
    res1_o.last = 1'b1;
    count_o     = {1'b0, va} + {1'b0, vb};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      td_q   <= '0;
      wl_q   <= '0;
    end else if (take_i) begin
      mode_q <= mode_d;
      td_q   <= td_d;
      wl_q   <= wl_d;
    end
  end

endmodule

[rtl/clt_out.sv]
module clt_out
  import clt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  res_t       res0_i,
  input  res_t       res1_i,
  input  logic [1:0] count_i,
  output logic       room_o,
  clt_out_if.source  out_o
);

  res_t       slot0_q, slot1_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign pop    = out_o.valid && out_o.ready;
  // take a new item only when the buffer is empty or empties this cycle
  assign room_o = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_o.ready);

  assign out_o.valid        = (cnt_q != 2'd0);
  assign out_o.token_kind   = slot0_q.kind;
  assign out_o.word_char    = slot0_q.wchar;
  assign out_o.token_closes = slot0_q.tend;
  assign out_o.token_index  = slot0_q.tidx;
  assign out_o.run_last     = slot0_q.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (take_i) begin
      cnt_q <= count_i;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      slot0_q <= res0_i;
      slot1_q <= res1_i;
    end else if (pop) begin
      slot0_q <= slot1_q;
    end
  end

endmodule

[rtl/command_line_tokenizer.sv]
// Streaming shell command-line lexer. Each input item is one character; a zero
// byte ends the line, emits an END token and clears the lexer for the next line.
// Each character yields zero, one or two result items, built in the same cycle
// it is accepted and held in a two-entry result buffer. A character is taken
// every cycle as long as the sink takes results; a character that yields two
// results holds the input while the second result drains.
module command_line_tokenizer
  import clt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  clt_in_if.sink    in_i,
  clt_out_if.source out_o
);

  res_t       res0, res1;
  logic [1:0] count;
  logic       room;
  logic       take;

  assign in_i.ready = room;
  assign take       = in_i.valid && room;

  clt_step u_step (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (take),
    .ch_i    (in_i.ch),
    .res0_o  (res0),
    .res1_o  (res1),
    .count_o (count)
  );

  clt_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (take),
    .res0_i  (res0),
    .res1_i  (res1),
    .count_i (count),
    .room_o  (room),
    .out_o   (out_o)
  );

endmodule

[tb/sv/command_line_tokenizer_test.sv]
module command_line_tokenizer_test
  import clt_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [CH_W-1:0] ch;
    int              n;
    res_t            first;
    res_t            second;
  } probe_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  clt_in_if  in_if ();
  clt_out_if out_if ();

  command_line_tokenizer dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #6 clk_i = ~clk_i;

  // Lexer state as seen by the predictor
  mode_e lex_mode  = MODE_IDLE;
  int    word_len  = 0;
  int    tok_count = 0;

  res_t   char_tokens[$];
  res_t   expected_tokens[$];
  probe_t probes[$];
  logic [CH_W-1:0] line_q[$];

  int   mismatches   = 0;
  int   chars_sent   = 0;
  int   burst_left   = 0;
  bit   gaps_off     = 1'b0;
  bit   hold_req     = 1'b0;
  int   typed_count  = -1;
  res_t typed_first  = '0;
  res_t typed_second = '0;

  function automatic res_t tok(kind_e k, logic [CH_W-1:0] wc, logic te,
                               logic [IDX_W-1:0] ix, logic lst);
    return '{kind: k, wchar: wc, tend: te, tidx: ix, last: lst};
  endfunction

  function automatic bit is_space_char(logic [CH_W-1:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit ends_word(logic [CH_W-1:0] c);
    case (c)
      CH_NUL, CH_PIPE, CH_LT, CH_GT, CH_AMP: return 1'b1;
      default: return is_space_char(c);
    endcase
  endfunction

  function automatic void put_token(kind_e k, logic [CH_W-1:0] wc, logic te);
    char_tokens.push_back(tok(k, wc, te, tok_count[IDX_W-1:0], 1'b0));
  endfunction

  function automatic void close_token();
    tok_count++;
    word_len = 0;
    lex_mode = (tok_count >= TOKEN_LIMIT - 1) ? MODE_SKIP : MODE_IDLE;
  endfunction

  function automatic void plain_char(logic [CH_W-1:0] c);
    logic cap;
    if (c == CH_NUL) begin
      put_token(KIND_END, CH_NUL, 1'b1);
      lex_mode  = MODE_IDLE;
      word_len  = 0;
      tok_count = 0;
      return;
    end
    if (lex_mode == MODE_SKIP || is_space_char(c)) return;
    case (c)
      CH_PIPE: begin
        put_token(KIND_PIPE, CH_NUL, 1'b1);
        close_token();
      end
      CH_LT: begin
        put_token(KIND_IN, CH_NUL, 1'b1);
        close_token();
      end
      CH_AMP: begin
        put_token(KIND_BG, CH_NUL, 1'b1);
        close_token();
      end
      CH_GT: lex_mode = MODE_PEND;
      default: begin
        // a word closes on the character that brings it to WORD_LIMIT-1
        cap = (word_len + 2 >= WORD_LIMIT);
        put_token(KIND_WORD, c, cap);
        word_len++;
        lex_mode = MODE_WORD;
        if (cap) close_token();
      end
    endcase
  endfunction

  function automatic void lex_step(logic [CH_W-1:0] c);
    char_tokens.delete();
    if (lex_mode == MODE_WORD && ends_word(c)) begin
      put_token(KIND_WORD, CH_NUL, 1'b1);
      close_token();
    end
    if (lex_mode == MODE_PEND) begin
      if (c == CH_GT) begin
        put_token(KIND_APPEND, CH_NUL, 1'b1);
        close_token();
      end else begin
        put_token(KIND_OUT, CH_NUL, 1'b1);
        close_token();
        plain_char(c);
      end
    end else begin
      plain_char(c);
    end
    if (char_tokens.size() > 0) char_tokens[char_tokens.size() - 1].last = 1'b1;
  endfunction

  function automatic logic [CH_W-1:0] rand_word_char();
    logic [CH_W-1:0] c;
    do c = CH_W'($urandom_range(1, 255)); while (ends_word(c));
    return c;
  endfunction

  function automatic logic [CH_W-1:0] rand_blank();
    return ($urandom_range(0, 2) == 0) ? CH_SPACE : CH_TAB + CH_W'($urandom_range(0, 4));
  endfunction

  function automatic void add_probe(input logic [CH_W-1:0] c, input int n,
                                    input res_t a = '0, input res_t b = '0);
    probe_t p;
    p.ch     = c;
    p.n      = n;
    p.first  = a;
    p.second = b;
    probes.push_back(p);
  endfunction

  // Offer one character; n >= 0 replaces the predicted tokens with typed ones
  task automatic send_char(input logic [CH_W-1:0] c, input int n, input res_t a,
                           input res_t b);
    if (burst_left == 0 && !gaps_off) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    typed_count  = n;
    typed_first  = a;
    typed_second = b;
    in_if.ch     = c;
    in_if.valid  = 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    chars_sent++;
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    res_t got, want;
    if (in_if.valid && in_if.ready) begin
      lex_step(in_if.ch);
      if (typed_count < 0) begin
        foreach (char_tokens[i]) expected_tokens.push_back(char_tokens[i]);
      end else begin
        if (typed_count > 0) expected_tokens.push_back(typed_first);
        if (typed_count > 1) expected_tokens.push_back(typed_second);
      end
    end
    if (out_if.valid && out_if.ready) begin
      got = tok(kind_e'(out_if.token_kind), out_if.word_char, out_if.token_closes,
                out_if.token_index, out_if.run_last);
      // fields shown as kind/char/end/index/last
      if (expected_tokens.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected token, expected none, actual %0d/%02h/%0b/%0d/%0b",
                 $time, got.kind, got.wchar, got.tend, got.tidx, got.last);
      end else begin
        want = expected_tokens.pop_front();
        if (got !== want) begin
          mismatches++;
          $display("%0t: token mismatch, expected %0d/%02h/%0b/%0d/%0b, actual %0d/%02h/%0b/%0d/%0b",
                   $time, want.kind, want.wchar, want.tend, want.tidx, want.last,
                   got.kind, got.wchar, got.tend, got.tidx, got.last);
        end
      end
    end
  end

  // Result sink: random stall patterns, plus one long hold-off on request
  initial begin
    int hold_left;
    int style;
    int style_left;
    int phase;
    hold_left    = 0;
    style        = 0;
    style_left   = 0;
    phase        = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      phase++;
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 150;
      end
      if (hold_left > 0) begin
        out_if.ready = 1'b0;
        hold_left--;
      end else begin
        if (style_left == 0) begin
          style      = $urandom_range(0, 3);
          style_left = $urandom_range(16, 96);
        end
        style_left--;
        case (style)
          0: out_if.ready = 1'b1;
          1: out_if.ready = $urandom_range(0, 1);
          2: out_if.ready = ($urandom_range(0, 4) != 0);
          default: out_if.ready = (phase % 3 != 0);
        endcase
      end
    end
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int line_no;
    int variant;
    rst_ni      = 1'b0;
    in_if.valid = 1'b0;
    in_if.ch    = CH_NUL;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    add_probe(CH_NUL, 1, tok(KIND_END, CH_NUL, 1'b1, 6'd0, 1'b1));
    add_probe(8'h61, 1, tok(KIND_WORD, 8'h61, 1'b0, 6'd0, 1'b1));
    add_probe(8'hFF, 1, tok(KIND_WORD, 8'hFF, 1'b0, 6'd0, 1'b1));
    add_probe(CH_SPACE, 1, tok(KIND_WORD, CH_NUL, 1'b1, 6'd0, 1'b1));
    add_probe(CH_PIPE, 1, tok(KIND_PIPE, CH_NUL, 1'b1, 6'd1, 1'b1));
    add_probe(CH_TAB, 0);
    add_probe(CH_LT, 1, tok(KIND_IN, CH_NUL, 1'b1, 6'd2, 1'b1));
    add_probe(CH_CR, 0);
    add_probe(CH_AMP, 1, tok(KIND_BG, CH_NUL, 1'b1, 6'd3, 1'b1));
    add_probe(CH_GT, 0);
    add_probe(CH_GT, 1, tok(KIND_APPEND, CH_NUL, 1'b1, 6'd4, 1'b1));
    add_probe(CH_GT, 0);
    add_probe(8'h78, 2, tok(KIND_OUT, CH_NUL, 1'b1, 6'd5, 1'b0),
              tok(KIND_WORD, 8'h78, 1'b0, 6'd6, 1'b1));
    add_probe(8'h01, -1);
    add_probe(CH_GT, -1);
    // zero byte right after a pending '>'
    add_probe(CH_NUL, 2, tok(KIND_OUT, CH_NUL, 1'b1, 6'd7, 1'b0),
              tok(KIND_END, CH_NUL, 1'b1, 6'd8, 1'b1));
    add_probe(8'h62, -1);
    // zero byte inside a word
    add_probe(CH_NUL, 2, tok(KIND_WORD, CH_NUL, 1'b1, 6'd0, 1'b0),
              tok(KIND_END, CH_NUL, 1'b1, 6'd1, 1'b1));
    add_probe(8'h0A, -1);
    add_probe(8'h0B, -1);
    add_probe(8'h0C, -1);
    add_probe(8'h7F, -1);
    add_probe(CH_PIPE, -1);
    add_probe(8'h08, -1);
    add_probe(8'h0E, -1);
    add_probe(CH_NUL, -1);
    foreach (probes[i]) send_char(probes[i].ch, probes[i].n, probes[i].first, probes[i].second);

    line_no = 0;
    while (chars_sent < 940 || line_no < 10) begin
      line_q.delete();
      case (line_no)
        1: begin
          // word at or past the length cap: the char reaching the cap closes it, any next char starts a new word
          line_q.push_back(CH_NUL);
          repeat ($urandom_range(WORD_LIMIT - 1, WORD_LIMIT + 6)) line_q.push_back(rand_word_char());
          if ($urandom_range(0, 1)) line_q.push_back(rand_blank());
          line_q.push_back(CH_NUL);
        end
        3, 5, 7, 9: begin
          // fill the line to TOKEN_LIMIT-2 tokens, one short of the point where tokens are skipped
          variant = (line_no - 3) / 2;
          line_q.push_back(CH_NUL);
          repeat (TOKEN_LIMIT - 2) begin
            case ($urandom_range(0, 4))
              0: line_q.push_back(CH_PIPE);
              1: line_q.push_back(CH_LT);
              2: line_q.push_back(CH_AMP);
              3: begin
                line_q.push_back(CH_GT);
                line_q.push_back(CH_GT);
              end
              default: begin
                line_q.push_back(rand_word_char());
                line_q.push_back(rand_blank());
              end
            endcase
          end
          case (variant)
            0: begin
              line_q.push_back(CH_PIPE);
              repeat (8) line_q.push_back(CH_W'($urandom_range(1, 255)));
            end
            1: begin
              line_q.push_back(CH_GT);
              line_q.push_back(rand_word_char());
              repeat (3) line_q.push_back(CH_W'($urandom_range(1, 255)));
            end
            2: line_q.push_back(CH_GT);
            default: begin
              line_q.push_back(CH_GT);
              line_q.push_back(CH_GT);
              line_q.push_back(rand_word_char());
            end
          endcase
          line_q.push_back(CH_NUL);
        end
        default: begin
          variant = $urandom_range(0, 99);
          if (variant < 65) begin
            repeat ($urandom_range(1, 8)) begin
              if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 2)) line_q.push_back(rand_blank());
              case ($urandom_range(0, 7))
                0: line_q.push_back(CH_PIPE);
                1: line_q.push_back(CH_LT);
                2: line_q.push_back(CH_AMP);
                3: line_q.push_back(CH_GT);
                4: begin
                  line_q.push_back(CH_GT);
                  line_q.push_back(CH_GT);
                end
                default: repeat ($urandom_range(1, 9)) line_q.push_back(rand_word_char());
              endcase
            end
            line_q.push_back(CH_NUL);
          end else if (variant < 85) begin
            repeat ($urandom_range(1, 16)) line_q.push_back(CH_W'($urandom_range(0, 255)));
            line_q.push_back(CH_NUL);
          end else begin
            // broken line: operator clutter, may leave state open for the next line
            repeat ($urandom_range(2, 14)) begin
              case ($urandom_range(0, 7))
                0, 1: line_q.push_back(CH_GT);
                2: line_q.push_back(CH_PIPE);
                3: line_q.push_back(CH_AMP);
                4: line_q.push_back(CH_LT);
                5: line_q.push_back(rand_blank());
                6: line_q.push_back(rand_word_char());
                default: line_q.push_back(CH_NUL);
              endcase
            end
            if ($urandom_range(0, 1)) line_q.push_back(CH_NUL);
          end
        end
      endcase

      if (line_no == 4) begin
        hold_req = 1'b1;
        gaps_off = 1'b1;
      end
      if (line_no == 6) begin
        // drain everything before going on
        in_if.valid = 1'b0;
        while (expected_tokens.size() != 0) @(negedge clk_i);
        repeat (3) @(negedge clk_i);
      end
      foreach (line_q[i]) send_char(line_q[i], -1, '0, '0);
      gaps_off = 1'b0;
      line_no++;
    end

    in_if.valid = 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
